// ----- rtl/tccw_pkg.sv -----
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants for the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

    // field widths
    localparam int CELL_W    = 16;
    localparam int COLOUR_W  = 8;
    localparam int CHAR_W    = 8;
    localparam int INDEX_W   = 11;
    localparam int COL_OUT_W = 7;
    localparam int ROW_OUT_W = 5;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    // special cell values and register reset
    localparam logic [CELL_W-1:0]   CURSOR_CELL  = 16'hF000;
    localparam logic [COLOUR_W-1:0] COLOUR_RESET = 8'd7;

    // operation codes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // kind of a put character
    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_NEWLINE,
        KIND_BACKSPACE,
        KIND_TAB
    } t_kind;

    // write data source
    typedef enum logic [2:0] {
        WSEL_ZERO,
        WSEL_CHAR,
        WSEL_SPACE,
        WSEL_CURSOR,
        WSEL_COPY
    } t_wsel;

    // write address source
    typedef enum logic {
        ASEL_CURSOR,
        ASEL_SWEEP
    } t_asel;

    // read address source
    typedef enum logic [1:0] {
        RSEL_INDEX,
        RSEL_CURSOR,
        RSEL_SCROLL
    } t_rsel;

    // cursor moves
    typedef enum logic [2:0] {
        MOVE_NONE,
        MOVE_ADV,
        MOVE_NEWLINE,
        MOVE_BACK,
        MOVE_BOTTOM
    } t_move;

    // controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_PUT,
        ST_POST,
        ST_NEWLINE,
        ST_BS_CLR,
        ST_BS_STEP,
        ST_BS_RD,
        ST_BS_CHK,
        ST_SC_RD,
        ST_SC_WR,
        ST_SC_CLR,
        ST_CURSOR,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic  latch;
        logic  mem_we;
        t_wsel wsel;
        t_asel asel;
        logic  mem_re;
        t_rsel rsel;
        t_move move;
        logic  sweep_clr;
        logic  sweep_inc;
        logic  tab_inc;
        logic  load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic  in_read;
        t_kind in_kind;
        t_kind kind;
        logic  row_past;
        logic  at_origin;
        logic  rdata_nz;
        logic  copy_last;
        logic  sweep_last;
        logic  tab_last;
    } t_sts;

    // classify a put character
    function automatic t_kind f_kind(input logic [CHAR_W-1:0] ch);
        t_kind k;
        if (ch == CH_NEWLINE) begin
            k = KIND_NEWLINE;
        end else if (ch == CH_BACKSPACE) begin
            k = KIND_BACKSPACE;
        end else if (ch == CH_TAB) begin
            k = KIND_TAB;
        end else begin
            k = KIND_CHAR;
        end
        return k;
    endfunction

endpackage

// ----- rtl/tccw_datapath.sv -----
// ----------------------------------------------------------------------------
// tccw_datapath
// Screen memory, cursor, colour register, sweep and tab counters, result word.
// ----------------------------------------------------------------------------
module tccw_datapath #(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int TAB_SPACES = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [tccw_pkg::S_TDATA_W-1:0]      i_s_tdata,
    input  logic                                i_s_tuser,
    input  logic                                i_cfg_wen,
    input  logic [tccw_pkg::COLOUR_W-1:0]       i_cfg_wdata,
    input  tccw_pkg::t_cmd                      i_cmd,
    output tccw_pkg::t_sts                      o_sts,
    output logic [tccw_pkg::CELL_W-1:0]         o_read_data,
    output logic [tccw_pkg::COL_OUT_W-1:0]      o_cursor_column,
    output logic [tccw_pkg::ROW_OUT_W-1:0]      o_cursor_row
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int TW    = $clog2(TAB_SPACES + 1);

    // screen memory
    logic [tccw_pkg::CELL_W-1:0] mem [CELLS];
    logic [tccw_pkg::CELL_W-1:0] r_rdata;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               rd_addr;
    logic [tccw_pkg::CELL_W-1:0] wr_data;

    // cursor, latched item, counters
    logic [CW-1:0]                   r_col, n_col;
    logic [RW-1:0]                   r_row, n_row;
    logic [AW-1:0]                   r_sweep;
    logic [TW-1:0]                   r_tab;
    logic [tccw_pkg::COLOUR_W-1:0]   r_colour;
    logic                            r_op;
    logic [tccw_pkg::CHAR_W-1:0]     r_char;
    logic [tccw_pkg::INDEX_W-1:0]    r_idx;
    tccw_pkg::t_kind                 r_kind;
    logic [AW-1:0]                   cur_addr;
    logic                            idx_ok;

    // result word
    logic [tccw_pkg::CELL_W-1:0]     r_out_data;
    logic [tccw_pkg::COL_OUT_W-1:0]  r_out_col;
    logic [tccw_pkg::ROW_OUT_W-1:0]  r_out_row;

    // cursor cell address
    assign cur_addr = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);
    assign idx_ok   = 32'(r_idx) < 32'(CELLS);

    // write address and data
    always_comb begin
        unique case (i_cmd.asel)
            tccw_pkg::ASEL_CURSOR: wr_addr = cur_addr;
            tccw_pkg::ASEL_SWEEP:  wr_addr = r_sweep;
            default:               wr_addr = cur_addr;
        endcase
        unique case (i_cmd.wsel)
            tccw_pkg::WSEL_ZERO:   wr_data = '0;
            tccw_pkg::WSEL_CHAR:   wr_data = {r_colour, r_char};
            tccw_pkg::WSEL_SPACE:  wr_data = {r_colour, tccw_pkg::CH_SPACE};
            tccw_pkg::WSEL_CURSOR: wr_data = tccw_pkg::CURSOR_CELL;
            tccw_pkg::WSEL_COPY:   wr_data = r_rdata;
            default:               wr_data = '0;
        endcase
    end

    // read address
    always_comb begin
        unique case (i_cmd.rsel)
            tccw_pkg::RSEL_INDEX:  rd_addr = AW'(r_idx);
            tccw_pkg::RSEL_CURSOR: rd_addr = cur_addr;
            tccw_pkg::RSEL_SCROLL: rd_addr = r_sweep + AW'(COLUMNS);
            default:               rd_addr = cur_addr;
        endcase
    end

    // memory write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.mem_re) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // cursor next value
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        unique case (i_cmd.move)
            tccw_pkg::MOVE_NONE: begin
            end
            tccw_pkg::MOVE_ADV: begin
                if (r_col == CW'(COLUMNS - 1)) begin
                    n_col = '0;
                    n_row = r_row + RW'(1);
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
            tccw_pkg::MOVE_NEWLINE: begin
                n_col = '0;
                n_row = r_row + RW'(1);
            end
            tccw_pkg::MOVE_BACK: begin
                if (r_col != '0) begin
                    n_col = r_col - CW'(1);
                end else if (r_row != '0) begin
                    n_col = CW'(COLUMNS - 1);
                    n_row = r_row - RW'(1);
                end
            end
            tccw_pkg::MOVE_BOTTOM: begin
                n_row = RW'(ROWS - 1);
            end
            default: begin
            end
        endcase
    end

    // control registers: cursor, counters, colour
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_sweep  <= '0;
            r_tab    <= '0;
            r_colour <= tccw_pkg::COLOUR_RESET;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cmd.sweep_clr) begin
                r_sweep <= '0;
            end else if (i_cmd.sweep_inc) begin
                r_sweep <= r_sweep + AW'(1);
            end
            if (i_cmd.latch) begin
                r_tab <= '0;
            end else if (i_cmd.tab_inc) begin
                r_tab <= r_tab + TW'(1);
            end
            if (i_cfg_wen) begin
                r_colour <= i_cfg_wdata;
            end
        end
    end

    // latched input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_s_tuser;
            r_char <= i_s_tdata[7:0];
            r_idx  <= i_s_tdata[18:8];
            r_kind <= tccw_pkg::f_kind(i_s_tdata[7:0]);
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= (r_op == tccw_pkg::OP_READ && idx_ok) ? r_rdata : '0;
            r_out_col  <= tccw_pkg::COL_OUT_W'(r_col);
            r_out_row  <= tccw_pkg::ROW_OUT_W'(r_row);
        end
    end

    // status
    always_comb begin
        o_sts.in_read    = i_s_tuser == tccw_pkg::OP_READ;
        o_sts.in_kind    = tccw_pkg::f_kind(i_s_tdata[7:0]);
        o_sts.kind       = r_kind;
        o_sts.row_past   = r_row == RW'(ROWS);
        o_sts.at_origin  = (r_col == '0) && (r_row == '0);
        o_sts.rdata_nz   = r_rdata != '0;
        o_sts.copy_last  = r_sweep == AW'((ROWS - 1) * COLUMNS - 1);
        o_sts.sweep_last = r_sweep == AW'(CELLS - 1);
        o_sts.tab_last   = r_tab == TW'(TAB_SPACES - 1);
    end

    assign o_read_data     = r_out_data;
    assign o_cursor_column = r_out_col;
    assign o_cursor_row    = r_out_row;

`ifndef SYNTHESIS
    // cursor column stays on the row
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < COLUMNS)
        else $error("cursor column out of range");

    // row can reach one past the bottom only until the scroll
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) <= ROWS)
        else $error("cursor row out of range");

    // scroll end puts the cursor on the bottom row
    a_row_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.move == tccw_pkg::MOVE_BOTTOM |=> r_row == RW'(ROWS - 1))
        else $error("cursor not on bottom row after scroll");
`endif

endmodule

// ----- rtl/tccw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tccw_ctrl
// Sequencer for clear, put, backspace walk, scroll and read operations.
// ----------------------------------------------------------------------------
module tccw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    input  tccw_pkg::t_sts  i_sts,
    output tccw_pkg::t_cmd  o_cmd
);

    tccw_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             accept;
    logic             out_free;

    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = r_state == tccw_pkg::ST_IDLE;
    assign o_m_tvalid = r_out_valid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tccw_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.wsel      = tccw_pkg::WSEL_ZERO;
        o_cmd.asel      = tccw_pkg::ASEL_CURSOR;
        o_cmd.rsel      = tccw_pkg::RSEL_CURSOR;
        o_cmd.move      = tccw_pkg::MOVE_NONE;
        n_out_valid     = r_out_valid && !i_m_tready;

        unique case (r_state)
            // zero the screen after reset
            tccw_pkg::ST_CLEAR: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.asel      = tccw_pkg::ASEL_SWEEP;
                o_cmd.sweep_inc = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = tccw_pkg::ST_IDLE;
                end
            end
            // take a word and dispatch
            tccw_pkg::ST_IDLE: begin
                if (accept) begin
                    o_cmd.latch = 1'b1;
                    if (i_sts.in_read) begin
                        n_state = tccw_pkg::ST_READ;
                    end else begin
                        unique case (i_sts.in_kind)
                            tccw_pkg::KIND_NEWLINE:   n_state = tccw_pkg::ST_NEWLINE;
                            tccw_pkg::KIND_BACKSPACE: n_state = tccw_pkg::ST_BS_CLR;
                            default:                  n_state = tccw_pkg::ST_PUT;
                        endcase
                    end
                end
            end
            tccw_pkg::ST_READ: begin
                o_cmd.mem_re = 1'b1;
                o_cmd.rsel   = tccw_pkg::RSEL_INDEX;
                n_state      = tccw_pkg::ST_DONE;
            end
            // write a character or a tab space and advance
            tccw_pkg::ST_PUT: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = (i_sts.kind == tccw_pkg::KIND_TAB) ?
                               tccw_pkg::WSEL_SPACE : tccw_pkg::WSEL_CHAR;
                o_cmd.move   = tccw_pkg::MOVE_ADV;
                n_state      = tccw_pkg::ST_POST;
            end
            tccw_pkg::ST_NEWLINE: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.move   = tccw_pkg::MOVE_NEWLINE;
                n_state      = tccw_pkg::ST_POST;
            end
            // scroll check, then next tab space or cursor
            tccw_pkg::ST_POST: begin
                priority if (i_sts.row_past) begin
                    o_cmd.sweep_clr = 1'b1;
                    n_state         = tccw_pkg::ST_SC_RD;
                end else if (i_sts.kind == tccw_pkg::KIND_TAB && !i_sts.tab_last) begin
                    o_cmd.tab_inc = 1'b1;
                    n_state       = tccw_pkg::ST_PUT;
                end else begin
                    n_state = tccw_pkg::ST_CURSOR;
                end
            end
            // backspace walk
            tccw_pkg::ST_BS_CLR: begin
                o_cmd.mem_we = 1'b1;
                n_state      = tccw_pkg::ST_BS_STEP;
            end
            tccw_pkg::ST_BS_STEP: begin
                if (i_sts.at_origin) begin
                    n_state = tccw_pkg::ST_CURSOR;
                end else begin
                    o_cmd.move = tccw_pkg::MOVE_BACK;
                    n_state    = tccw_pkg::ST_BS_RD;
                end
            end
            tccw_pkg::ST_BS_RD: begin
                o_cmd.mem_re = 1'b1;
                n_state      = tccw_pkg::ST_BS_CHK;
            end
            tccw_pkg::ST_BS_CHK: begin
                n_state = i_sts.rdata_nz ? tccw_pkg::ST_CURSOR : tccw_pkg::ST_BS_STEP;
            end
            // scroll: copy one row up, then clear the bottom row
            tccw_pkg::ST_SC_RD: begin
                o_cmd.mem_re = 1'b1;
                o_cmd.rsel   = tccw_pkg::RSEL_SCROLL;
                n_state      = tccw_pkg::ST_SC_WR;
            end
            tccw_pkg::ST_SC_WR: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.wsel      = tccw_pkg::WSEL_COPY;
                o_cmd.asel      = tccw_pkg::ASEL_SWEEP;
                o_cmd.sweep_inc = 1'b1;
                n_state = i_sts.copy_last ? tccw_pkg::ST_SC_CLR : tccw_pkg::ST_SC_RD;
            end
            tccw_pkg::ST_SC_CLR: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.asel      = tccw_pkg::ASEL_SWEEP;
                o_cmd.sweep_inc = 1'b1;
                if (i_sts.sweep_last) begin
                    o_cmd.move = tccw_pkg::MOVE_BOTTOM;
                    n_state    = tccw_pkg::ST_POST;
                end
            end
            // draw the cursor and hand over the result
            tccw_pkg::ST_CURSOR: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = tccw_pkg::WSEL_CURSOR;
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = tccw_pkg::ST_IDLE;
                end else begin
                    n_state = tccw_pkg::ST_DONE;
                end
            end
            tccw_pkg::ST_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = tccw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tccw_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // result register only loads into a free slot
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_m_tready))
        else $error("result overwritten before taken");

    // an accepted word starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != tccw_pkg::ST_IDLE)
        else $error("accepted word dropped");

    // a new result only comes from the finishing states
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == tccw_pkg::ST_CURSOR ||
                                $past(r_state) == tccw_pkg::ST_DONE))
        else $error("result raised outside finish");
`endif

endmodule

// ----- rtl/text_console_character_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_character_writer
// Text screen of 16-bit cells with a cursor; put and read words in, one
// result word out per input word.
// ----------------------------------------------------------------------------
// channel   direction  handshake                 content
// s         in         i_s_tvalid / o_s_tready   operation (tuser), char_code, cell_index
// m         out        o_m_tvalid / i_m_tready   read_data, cursor_column, cursor_row
// cfg       in         i_cfg_wen                 char_colour
//
// a put writes its cell, checks for a scroll, then draws the cursor; a read fetches
// the cell; a tab writes TAB_SPACES spaces; a backspace clears the cell and walks
// back to the nearest non-empty cell or the origin; a scroll copies by read then
// write, then clears the bottom row. after reset the screen is zeroed with
// o_s_tready low. one word in flight; a finished word waits in the output register
// while the next word is taken.
// ----------------------------------------------------------------------------
module text_console_character_writer #(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int TAB_SPACES = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // s word: tdata [7:0] char_code, [18:8] cell_index, [23:19] zero
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [tccw_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // s tuser: [0] operation
    input  logic                               i_s_tuser,
    // m word: [15:0] read_data, [22:16] cursor_column, [27:23] cursor_row, [31:28] zero
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [tccw_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // colour register write
    input  logic                               i_cfg_wen,
    input  logic [tccw_pkg::COLOUR_W-1:0]      i_cfg_wdata
);

    tccw_pkg::t_cmd                    cmd;
    tccw_pkg::t_sts                    sts;
    logic [tccw_pkg::CELL_W-1:0]       read_data;
    logic [tccw_pkg::COL_OUT_W-1:0]    cursor_column;
    logic [tccw_pkg::ROW_OUT_W-1:0]    cursor_row;

    // sequencer
    tccw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // screen and cursor
    tccw_datapath #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .TAB_SPACES (TAB_SPACES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tdata       (i_s_tdata),
        .i_s_tuser       (i_s_tuser),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_read_data     (read_data),
        .o_cursor_column (cursor_column),
        .o_cursor_row    (cursor_row)
    );

    // pack the result word
    assign o_m_tdata = {4'b0000, cursor_row, cursor_column, read_data};

endmodule

// ----- verif/tccw_checker.sv -----
// ----------------------------------------------------------------------------
// tccw_checker
// Watches the word channels of the text console character writer, keeps its
// own copy of the screen, cursor and colour, predicts one result word per
// accepted input word and compares results field by field in order.
// ----------------------------------------------------------------------------
module tccw_checker #(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int TAB_SPACES = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    input  logic                                 i_s_tready,
    input  logic [tccw_pkg::S_TDATA_W-1:0]       i_s_tdata,
    input  logic                                 i_s_tuser,
    input  logic                                 i_m_tvalid,
    input  logic                                 i_m_tready,
    input  logic [tccw_pkg::M_TDATA_W-1:0]       i_m_tdata,
    input  logic                                 i_cfg_wen,
    input  logic [tccw_pkg::COLOUR_W-1:0]        i_cfg_wdata,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int DW    = tccw_pkg::CELL_W;
    localparam int CLW   = tccw_pkg::COL_OUT_W;
    localparam int RWW   = tccw_pkg::ROW_OUT_W;
    localparam int CHW   = tccw_pkg::CHAR_W;
    localparam int IXW   = tccw_pkg::INDEX_W;

    typedef struct packed {
        logic [DW-1:0]  read_data;
        logic [CLW-1:0] cursor_column;
        logic [RWW-1:0] cursor_row;
    } t_console_result;

    // shadow screen, cursor and colour
    logic [DW-1:0]                  screen_mem [CELLS];
    int                             cur_col;
    int                             cur_row;
    logic [tccw_pkg::COLOUR_W-1:0]  glyph_colour;

    t_console_result console_results_q [$];

    function automatic int cursor_cell();
        return (cur_col % COLUMNS) + (cur_row % ROWS) * COLUMNS;
    endfunction

    // scroll up one row once the cursor falls past the bottom
    function automatic void scroll_up();
        if (cur_row >= ROWS) begin
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                screen_mem[i] = screen_mem[i + COLUMNS];
            for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
                screen_mem[i] = '0;
            cur_row = ROWS - 1;
        end
    endfunction

    function automatic void write_glyph(input logic [CHW-1:0] ch);
        screen_mem[cursor_cell()] = {glyph_colour, ch};
        cur_col = (cur_col + 1) % COLUMNS;
        if (cur_col == 0)
            cur_row++;
        scroll_up();
    endfunction

    function automatic void line_feed();
        screen_mem[cursor_cell()] = '0;
        cur_col = 0;
        cur_row++;
        scroll_up();
    endfunction

    // clear back to the nearest non-empty cell, stopping at the origin
    function automatic void erase_back();
        screen_mem[cursor_cell()] = '0;
        while (1'b1) begin
            if (cur_col > 0) begin
                cur_col--;
            end else if (cur_row > 0) begin
                cur_row--;
                cur_col = COLUMNS - 1;
            end else begin
                break;
            end
            if (screen_mem[cursor_cell()] != '0)
                break;
        end
        screen_mem[cursor_cell()] = '0;
    endfunction

    function automatic t_console_result predict_console(
        input logic                             op,
        input logic [tccw_pkg::S_TDATA_W-1:0]   w
    );
        logic [CHW-1:0]  ch;
        logic [IXW-1:0]  idx;
        t_console_result r;
        ch  = w[CHW-1:0];
        idx = w[CHW+IXW-1:CHW];
        r.read_data = '0;
        if (op == tccw_pkg::OP_READ) begin
            if (idx < CELLS)
                r.read_data = screen_mem[idx];
        end else begin
            case (ch)
                tccw_pkg::CH_NEWLINE:   line_feed();
                tccw_pkg::CH_BACKSPACE: erase_back();
                tccw_pkg::CH_TAB: begin
                    for (int i = 0; i < TAB_SPACES; i++)
                        write_glyph(tccw_pkg::CH_SPACE);
                end
                default:                write_glyph(ch);
            endcase
            screen_mem[cursor_cell()] = tccw_pkg::CURSOR_CELL;
        end
        r.cursor_column = cur_col[CLW-1:0];
        r.cursor_row    = cur_row[RWW-1:0];
        return r;
    endfunction

    // per-edge observation: results first, then colour, then new words
    always @(posedge i_clk) begin
        t_console_result want;
        t_console_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++)
                screen_mem[i] = '0;
            cur_col      = 0;
            cur_row      = 0;
            glyph_colour = tccw_pkg::COLOUR_RESET;
            console_results_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.read_data     = i_m_tdata[DW-1:0];
                got.cursor_column = i_m_tdata[DW+CLW-1:DW];
                got.cursor_row    = i_m_tdata[DW+CLW+RWW-1:DW+CLW];
                if (console_results_q.size() == 0) begin
                    $error("result word %h with no expectation waiting", i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = console_results_q.pop_front();
                    if (got.read_data !== want.read_data) begin
                        $error("read_data: expected %h, actual %h",
                               want.read_data, got.read_data);
                        o_fail_count++;
                    end
                    if (got.cursor_column !== want.cursor_column) begin
                        $error("cursor_column: expected %0d, actual %0d",
                               want.cursor_column, got.cursor_column);
                        o_fail_count++;
                    end
                    if (got.cursor_row !== want.cursor_row) begin
                        $error("cursor_row: expected %0d, actual %0d",
                               want.cursor_row, got.cursor_row);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_wen)
                glyph_colour = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready)
                console_results_q.push_back(predict_console(i_s_tuser, i_s_tdata));
        end
        o_pending <= console_results_q.size();
    end

endmodule

// ----- verif/tb_text_console_character_writer.sv -----
// ----------------------------------------------------------------------------
// tb_text_console_character_writer
// Drives put and read words into the text console character writer with
// random gaps and stalls: a directed opening, then phases of random console
// traffic under different colours. A checker beside the block predicts and
// compares every result word; the top gives the verdict.
// ----------------------------------------------------------------------------
module tb_text_console_character_writer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int TAB_SPACES  = 4;
    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 165;
    localparam int STALL_LIMIT = 40000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 400;
    localparam int CALM_PHASE  = 2;
    localparam int CHW         = tccw_pkg::CHAR_W;
    localparam int IXW         = tccw_pkg::INDEX_W;
    localparam int SDW         = tccw_pkg::S_TDATA_W;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [SDW-1:0]                       s_tdata;
    logic                                 s_tuser;
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic [tccw_pkg::M_TDATA_W-1:0]       m_tdata;
    logic                                 cfg_wen;
    logic [tccw_pkg::COLOUR_W-1:0]        cfg_wdata;
    int                                   fail_count;
    int                                   pending;
    int                                   results_seen = 0;
    bit                                   no_idle = 1'b0;

    text_console_character_writer #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .TAB_SPACES (TAB_SPACES)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_wen   (cfg_wen),
        .i_cfg_wdata (cfg_wdata)
    );

    tccw_checker #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .TAB_SPACES (TAB_SPACES)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_wen    (cfg_wen),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result words taken so far, used to time the long receiver hold
    always @(posedge clk) begin
        if (m_tvalid && m_tready)
            results_seen <= results_seen + 1;
    end

    // receiver: random stalls, one long hold once traffic is under way
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                m_tready  <= 1'b0;
                hold_left = HOLD_CYCLES - 1;
                hold_done = 1'b1;
            end else begin
                m_tready <= no_idle || ($urandom_range(99) >= 16);
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // entered and left at a falling edge; tvalid is left high when the task returns
    task automatic send_word(input logic op,
                             input logic [CHW-1:0] ch,
                             input logic [IXW-1:0] idx);
        while (!no_idle && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(SDW-CHW-IXW){1'b0}}, idx, ch};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_colour(input logic [tccw_pkg::COLOUR_W-1:0] c);
        cfg_wen   <= 1'b1;
        cfg_wdata <= c;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        @(negedge clk);
    endtask

    // random console traffic: mostly text lines, some control and reads
    task automatic send_console_traffic(input int count);
        int              pick;
        int              burst;
        logic [CHW-1:0]  ch;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                send_word(tccw_pkg::OP_READ, CHW'($urandom),
                          IXW'($urandom_range(2047)));
            end else if (pick < 24) begin
                send_word(tccw_pkg::OP_PUT, tccw_pkg::CH_NEWLINE, IXW'($urandom));
            end else if (pick < 29) begin
                send_word(tccw_pkg::OP_PUT, tccw_pkg::CH_TAB, IXW'($urandom));
            end else if (pick < 33) begin
                send_word(tccw_pkg::OP_PUT, tccw_pkg::CH_BACKSPACE, IXW'($urandom));
            end else if (pick < 34) begin
                // a run of backspaces reaching back over several cells
                burst = $urandom_range(10, 3);
                for (int b = 0; b < burst; b++)
                    send_word(tccw_pkg::OP_PUT, tccw_pkg::CH_BACKSPACE,
                              IXW'($urandom));
            end else begin
                if ($urandom_range(99) < 75)
                    ch = CHW'($urandom_range(126, 32));
                else
                    ch = CHW'($urandom_range(255));
                send_word(tccw_pkg::OP_PUT, ch, IXW'($urandom));
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed opening under the reset colour
        send_word(tccw_pkg::OP_READ, '0, 11'd0);
        send_word(tccw_pkg::OP_READ, '1, 11'd2047);   // past the last cell
        send_word(tccw_pkg::OP_READ, '0, 11'd1999);
        send_word(tccw_pkg::OP_PUT, 8'h41, '0);
        send_word(tccw_pkg::OP_PUT, 8'hFF, '1);
        send_word(tccw_pkg::OP_PUT, 8'h00, '0);
        send_word(tccw_pkg::OP_PUT, tccw_pkg::CH_TAB, '0);
        send_word(tccw_pkg::OP_PUT, tccw_pkg::CH_NEWLINE, '0);
        send_word(tccw_pkg::OP_PUT, 8'h80, '0);
        send_word(tccw_pkg::OP_READ, '0, 11'd80);
        // walk back over the first line down to the origin, then three more times
        for (int i = 0; i < 11; i++)
            send_word(tccw_pkg::OP_PUT, tccw_pkg::CH_BACKSPACE, '0);
        send_word(tccw_pkg::OP_READ, '0, 11'd0);
        send_word(tccw_pkg::OP_READ, '0, 11'd1);
        drain_results();

        // random phases, each under its own colour; extremes first
        for (int p = 0; p < PHASES; p++) begin
            if (p == 0)
                set_colour(8'h00);
            else if (p == 1)
                set_colour(8'hFF);
            else
                set_colour(tccw_pkg::COLOUR_W'($urandom));
            no_idle = (p == CALM_PHASE);
            send_console_traffic(PHASE_WORDS);
            drain_results();
        end
        no_idle = 1'b0;

        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/tccw_pkg.sv
rtl/tccw_datapath.sv
rtl/tccw_ctrl.sv
rtl/text_console_character_writer.sv
verif/tccw_checker.sv
verif/tb_text_console_character_writer.sv
